/* design/lookahead_peak_limiter_unit_defines.svh */
// ----------------------------------------------------------------------------
// Lookahead peak limiter assertion macros
// Shared concurrent assertion helpers for the limiter RTL.
// ----------------------------------------------------------------------------
`ifndef LOOKAHEAD_PEAK_LIMITER_UNIT_DEFINES_SVH
`define LOOKAHEAD_PEAK_LIMITER_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define LPL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define LPL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/lpl_pkg.sv */
// ----------------------------------------------------------------------------
// Lookahead peak limiter package
// Shared types, register indexes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none
package lpl_pkg;

   localparam int CHANNELS_DEF = 2;
   localparam int DEPTH_DEF    = 128;
   localparam int NUM_INPUTS   = 2;

   localparam logic [30:0] Q31_ONE = 31'h7FFF_FFFF;

   // register reset values
   localparam logic [30:0] THRESHOLD_RST = 31'h4000_0000;
   localparam logic [30:0] ATTACK_RST    = 31'd22369621;
   localparam logic [30:0] RELEASE_RST   = 31'd44739;
   localparam logic [15:0] HOLD_RST      = 16'd480;
   localparam logic [7:0]  LOOKAHEAD_RST = 8'd96;
   localparam logic [1:0]  NCH_RST       = 2'd2;

   typedef enum logic [2:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_ATTACK    = 3'd1,
      CSR_RELEASE   = 3'd2,
      CSR_HOLD      = 3'd3,
      CSR_LOOKAHEAD = 3'd4,
      CSR_CHANNELS  = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PEAK,
      S_DIV_START,
      S_DIV_WAIT,
      S_MUL_A,
      S_MUL_B,
      S_RELEASE,
      S_MUL_C,
      S_MUL_D,
      S_GAIN,
      S_MUL_S,
      S_CLAMP,
      S_WB,
      S_OUT
   } state_type;

   // divider handshake
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

/* design/lpl_div.sv */
// ----------------------------------------------------------------------------
// Limiter gain divider
// Restoring divider, one quotient bit per cycle: 31-bit by 16-bit.
// ----------------------------------------------------------------------------
`default_nettype none
module lpl_div
   import lpl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [30:0]  dividend,
   input  wire logic [15:0]  divisor,
   output div_stat_type      stat,
   output logic [30:0]       quotient
);

   logic [30:0] num_ff, num_in;
   logic [30:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   // one shift-subtract step per cycle
   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], num_ff[30]};
      if (start) begin
         num_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 5'd30;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[29:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[29:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[29:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

/* design/lpl_delay_mem.sv */
// ----------------------------------------------------------------------------
// Limiter delay memory
// One row per delay slot, one 32-bit lane per channel; cleared after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module lpl_delay_mem
   import lpl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int LANES = 2,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        addr,
   input  wire logic [LANES*32-1:0]  wdata,
   output logic [LANES*32-1:0]       rdata,
   output logic                      busy
);

   logic [LANES*32-1:0] mem [DEPTH];
   logic [LANES*32-1:0] rdata_ff;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                busy_ff, busy_in;

   // clearing pass, one row per cycle
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (clr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end else begin
            clr_in = clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
   assign busy  = busy_ff;

endmodule
`default_nettype wire

/* design/lookahead_peak_limiter_unit.sv */
// ----------------------------------------------------------------------------
// Lookahead peak limiter
// Peak detect, gain computation and delayed, limited output per frame.
// ----------------------------------------------------------------------------
// When the peak exceeds the threshold, the restoring divider forms the target
// gain: 31 quotient bits, then done is reported. When it does not, the divider
// is skipped. After that, one shared 32x32 multiplier runs the release, attack
// and per-channel scaling products one after another. Only one frame is worked
// on at a time. The next frame can be taken in the cycle after the result is
// loaded into the output register. A full output register holds the finished
// frame until the register frees up. After reset, the delay memory is cleared
// one row per cycle, and no frame is taken until the clear ends. Configuration
// writes are taken during that time.
`default_nettype none
`include "lookahead_peak_limiter_unit_defines.svh"
module lookahead_peak_limiter_unit
   import lpl_pkg::*;
#(
   parameter int CHANNELS        = CHANNELS_DEF,
   parameter int LOOKAHEAD_DEPTH = DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // chan0_sample, chan1_sample
   input  wire logic [63:0]  req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // chan0_out, chan1_out, gain_out, zero pad
   output logic [95:0]       rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_wen,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [30:0]  csr_wdata
);

   localparam int LANES = (CHANNELS < NUM_INPUTS) ? CHANNELS : NUM_INPUTS;
   localparam int AW    = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;
   localparam int CW    = (AW + 1 > 9) ? AW + 1 : 9;
   localparam int CHW   = (LANES > 1) ? $clog2(LANES) : 1;

   // configuration registers
   logic [30:0] thr_ff, att_ff, rel_ff;
   logic [15:0] hold_len_ff;
   logic [7:0]  look_ff;
   logic [1:0]  nch_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THRESHOLD_RST;
         att_ff      <= ATTACK_RST;
         rel_ff      <= RELEASE_RST;
         hold_len_ff <= HOLD_RST;
         look_ff     <= LOOKAHEAD_RST;
         nch_cfg_ff  <= NCH_RST;
      end else if (csr_wen) begin
         case (csr_idx_type'(csr_addr))
            CSR_THRESHOLD: thr_ff      <= csr_wdata;
            CSR_ATTACK:    att_ff      <= csr_wdata;
            CSR_RELEASE:   rel_ff      <= csr_wdata;
            CSR_HOLD:      hold_len_ff <= csr_wdata[15:0];
            CSR_LOOKAHEAD: look_ff     <= csr_wdata[7:0];
            CSR_CHANNELS:  nch_cfg_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // channels in use and effective delay length
   logic [1:0]    nch;
   logic [CW-1:0] len_eff;
   logic [LANES-1:0] lane_on;

   always_comb begin
      nch = (32'(nch_cfg_ff) > LANES) ? 2'(LANES) : nch_cfg_ff;
      len_eff = (look_ff == 8'd0) ? CW'(1) : CW'(look_ff);
      if (len_eff > CW'(LOOKAHEAD_DEPTH)) begin
         len_eff = CW'(LOOKAHEAD_DEPTH);
      end
      for (int l = 0; l < LANES; l++) begin
         lane_on[l] = (l < 32'(nch));
      end
   end

   state_type state_ff, state_in;

   logic [63:0]       smp_ff;
   logic [30:0]       peak_ff, peak_in;
   logic [30:0]       target_ff, target_in;
   logic [30:0]       env_ff, env_in;
   logic [30:0]       gain_ff, gain_in;
   logic [15:0]       hold_ff, hold_in;
   logic [30:0]       acc_ff, acc_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CHW-1:0]    ch_ff, ch_in;
   logic [31:0]       y_ff [2];
   logic [63:0]       prod_ff;
   logic [30:0]       mul_a;
   logic [31:0]       mul_b;
   logic [95:0]       rsp_data_ff;
   logic              rsp_valid_ff;

   logic              accept;
   logic              rsp_free;
   logic              mem_busy;
   logic              mem_wr;
   logic [LANES*32-1:0] mem_wdata, mem_rdata;
   logic              div_start;
   div_stat_type      div_stat;
   logic [30:0]       div_q;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (accept) state_in = S_PEAK;
         S_PEAK:      state_in = S_DIV_START;
         S_DIV_START: state_in = (peak_ff > thr_ff) ? S_DIV_WAIT : S_MUL_A;
         S_DIV_WAIT:  if (div_stat.done) state_in = S_MUL_A;
         S_MUL_A:     state_in = S_MUL_B;
         S_MUL_B:     state_in = S_RELEASE;
         S_RELEASE:   state_in = S_MUL_C;
         S_MUL_C:     state_in = S_MUL_D;
         S_MUL_D:     state_in = S_GAIN;
         S_GAIN:      state_in = S_MUL_S;
         S_MUL_S:     state_in = S_CLAMP;
         S_CLAMP:     state_in = (32'(ch_ff) == LANES - 1) ? S_WB : S_MUL_S;
         S_WB:        state_in = S_OUT;
         S_OUT:       if (rsp_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // control outputs and shared multiplier operands
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      mem_wr     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         S_IDLE:      req_tready = !mem_busy;
         S_DIV_START: div_start  = (peak_ff > thr_ff);
         S_MUL_A: begin
            mul_a = target_ff;
            mul_b = {1'b0, rel_ff};
         end
         S_MUL_B: begin
            mul_a = env_ff;
            mul_b = {1'b0, Q31_ONE - rel_ff};
         end
         S_MUL_C: begin
            mul_a = env_ff;
            mul_b = {1'b0, att_ff};
         end
         S_MUL_D: begin
            mul_a = gain_ff;
            mul_b = {1'b0, Q31_ONE - att_ff};
         end
         S_MUL_S: begin
            mul_a = gain_ff;
            mul_b = mem_rdata[32*32'(ch_ff) +: 32];
         end
         S_WB:        mem_wr = 1'b1;
         default: ;
      endcase
   end

   // peak magnitude over active channels, low half cleared
   logic [30:0] peak_c;
   logic [31:0] s_c;
   logic [30:0] mag_c;
   always_comb begin
      peak_c = '0;
      for (int l = 0; l < LANES; l++) begin
         s_c = smp_ff[32*l +: 32];
         if (!s_c[31]) begin
            mag_c = s_c[30:0];
         end else if (s_c == 32'h8000_0000) begin
            mag_c = Q31_ONE;
         end else begin
            mag_c = 31'(~s_c + 32'd1);
         end
         if (lane_on[l] && mag_c > peak_c) begin
            peak_c = mag_c;
         end
      end
      peak_in = {peak_c[30:16], 16'd0};
   end

   // release, hold and attack datapath
   logic [31:0] sum_c;
   logic [32:0] y_c;
   logic [32:0] lim_c;
   always_comb begin
      target_in = target_ff;
      env_in    = env_ff;
      hold_in   = hold_ff;
      gain_in   = gain_ff;
      acc_in    = acc_ff;
      ch_in     = ch_ff;
      sum_c     = {1'b0, acc_ff} + {1'b0, prod_ff[61:31]};
      lim_c     = {2'b00, thr_ff};
      y_c       = prod_ff[63:31];
      if (y_c[32] == 1'b0 && y_c > lim_c) begin
         y_c = lim_c;
      end else if (y_c[32] && $signed(y_c) < -$signed(lim_c)) begin
         y_c = -lim_c;
      end
      case (state_ff)
         S_DIV_START: if (!(peak_ff > thr_ff)) target_in = Q31_ONE;
         S_DIV_WAIT:  if (div_stat.done) target_in = {div_q[15:0], 15'd0};
         S_MUL_B, S_MUL_D: acc_in = prod_ff[61:31];
         S_RELEASE: begin
            if ({1'b0, target_ff} < sum_c) begin
               env_in  = target_ff;
               hold_in = hold_len_ff;
            end else if (hold_ff != 16'd0) begin
               hold_in = hold_ff - 16'd1;
            end else begin
               env_in = sum_c[30:0];
            end
         end
         S_GAIN: begin
            gain_in = sum_c[30:0];
            ch_in   = '0;
         end
         S_CLAMP: ch_in = ch_ff + 1'b1;
         default: ;
      endcase
   end

   // delay row write-back, inactive lanes keep their old data
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mem_wdata[32*l +: 32] = lane_on[l] ? smp_ff[32*l +: 32] : mem_rdata[32*l +: 32];
      end
   end

   // pointer advance
   logic [CW-1:0] ptr_nxt;
   always_comb begin
      ptr_in  = ptr_ff;
      ptr_nxt = CW'(ptr_ff) + CW'(1);
      if (state_ff == S_WB) begin
         ptr_in = (ptr_nxt >= len_eff) ? '0 : ptr_nxt[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         env_ff       <= Q31_ONE;
         gain_ff      <= Q31_ONE;
         hold_ff      <= HOLD_RST;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         env_ff   <= env_in;
         gain_ff  <= gain_in;
         hold_ff  <= hold_in;
         ptr_ff   <= ptr_in;
         if (state_ff == S_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         smp_ff <= req_tdata;
      end
      if (state_ff == S_PEAK) begin
         peak_ff <= peak_in;
      end
      if (state_ff == S_CLAMP) begin
         y_ff[ch_ff] <= lane_on[ch_ff] ? y_c[31:0] : 32'd0;
      end
      if (state_ff == S_OUT && rsp_free) begin
         rsp_data_ff <= {1'b0, gain_ff,
                         (LANES > 1 && nch > 2'd1) ? y_ff[1] : 32'd0,
                         (nch > 2'd0) ? y_ff[0] : 32'd0};
      end
      target_ff <= target_in;
      acc_ff    <= acc_in;
      ch_ff     <= ch_in;
      prod_ff   <= $signed({1'b0, mul_a}) * $signed(mul_b);
   end

   lpl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (thr_ff),
      .divisor  ({1'b0, peak_ff[30:16]}),
      .stat     (div_stat),
      .quotient (div_q)
   );

   lpl_delay_mem #(
      .DEPTH (LOOKAHEAD_DEPTH),
      .LANES (LANES)
   ) u_mem (
      .clock (clock),
      .reset (reset),
      .rd_en (accept),
      .wr_en (mem_wr),
      .addr  (ptr_ff),
      .wdata (mem_wdata),
      .rdata (mem_rdata),
      .busy  (mem_busy)
   );

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   `LPL_ASSERT(a_no_accept_clearing, mem_busy |-> !req_tready, "frame taken during clear")
   `LPL_ASSERT(a_div_start_idle, div_start |-> !div_stat.busy, "divider restarted while busy")
   `LPL_ASSERT(a_rsp_loaded, (state_ff == S_OUT && rsp_free) |=> rsp_valid_ff, "result lost")
   `LPL_ASSERT(a_ptr_range, ptr_ff < AW'(LOOKAHEAD_DEPTH - 1) || ptr_ff == AW'(LOOKAHEAD_DEPTH - 1), "pointer range")

endmodule
`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Lookahead peak limiter testbench
// Streams Q31 frames through the limiter under several register settings and
// random idling on both sides. Every result is checked field by field against
// a cycle-free model of the limiter kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import lpl_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 60;
   localparam logic [2:0] CSR_UNUSED = 3'd6;

   typedef struct packed {
      logic [31:0] chan0;
      logic [31:0] chan1;
      logic [30:0] gain;
   } frame_out_type;

   typedef struct {
      logic [31:0] s0;
      logic [31:0] s1;
      bit          zero_out;
   } stim_row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic [63:0]  req_tdata = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [95:0]  rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic         csr_wen = 0;
   logic [2:0]   csr_addr = '0;
   logic [30:0]  csr_wdata = '0;

   // limiter model state and registers
   logic [31:0] dly_mem [0:1][0:DEPTH-1];
   int          dly_ptr;
   logic [15:0] hold_cnt;
   logic [31:0] gain_q;
   logic [31:0] env_q;
   logic [30:0] thr_reg, atk_reg, rel_reg;
   logic [15:0] hold_reg;
   logic [7:0]  look_reg;
   logic [1:0]  nch_reg;

   frame_out_type expected_frames[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int recv_holdoff = 0;
   int cycles = 0;

   lookahead_peak_limiter_unit i_dut (
      .clock, .reset,
      .req_tdata, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tvalid, .rsp_tready,
      .csr_wen, .csr_addr, .csr_wdata
   );

   always #1 clock = ~clock;

   // floored Q31 product of two non-negative values
   function automatic logic [31:0] q31_umul(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      p = {32'b0, a} * {32'b0, b};
      return p[62:31];
   endfunction

   // floored Q31 product of a gain and a signed sample
   function automatic logic [31:0] q31_scale(logic [31:0] g, logic [31:0] s);
      longint p;
      p = longint'(g) * longint'($signed(s));
      return 32'(p >>> 31);
   endfunction

   // advance the limiter model by one frame
   function automatic frame_out_type limit_frame(logic [31:0] s0, logic [31:0] s1);
      frame_out_type r;
      int          nch, len;
      logic [31:0] peak, mag, tgt, relax, smp, y;
      logic [31:0] samp [0:1];
      longint      lim, ys;
      nch = (nch_reg > 2) ? 2 : nch_reg;
      len = (look_reg == 0) ? 1 : ((look_reg > DEPTH) ? DEPTH : look_reg);
      samp[0] = s0;
      samp[1] = s1;
      peak = 0;
      for (int c = 0; c < nch; c++) begin
         smp = samp[c];
         if (smp == 32'h8000_0000) mag = 32'h7FFF_FFFF;
         else if (smp[31]) mag = -smp;
         else mag = smp;
         if (mag > peak) peak = mag;
      end
      peak &= 32'hFFFF_0000;
      if (peak > 32'(thr_reg)) tgt = (32'(thr_reg) / (peak >> 16)) << 15;
      else tgt = 32'(Q31_ONE);
      relax = q31_umul(tgt, 32'(rel_reg)) + q31_umul(env_q, 32'(Q31_ONE - rel_reg));
      if (tgt < relax) begin
         env_q = tgt;
         hold_cnt = hold_reg;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
      end else begin
         env_q = relax;
      end
      gain_q = q31_umul(env_q, 32'(atk_reg)) + q31_umul(gain_q, 32'(Q31_ONE - atk_reg));
      r.chan0 = 0;
      r.chan1 = 0;
      lim = longint'(thr_reg);
      for (int c = 0; c < nch; c++) begin
         ys = longint'($signed(q31_scale(gain_q, dly_mem[c][dly_ptr])));
         if (ys > lim) ys = lim;
         if (ys < -lim) ys = -lim;
         y = 32'(ys);
         dly_mem[c][dly_ptr] = samp[c];
         if (c == 0) r.chan0 = y;
         else r.chan1 = y;
      end
      r.gain = gain_q[30:0];
      dly_ptr++;
      if (dly_ptr >= len) dly_ptr = 0;
      return r;
   endfunction

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (recv_holdoff > 0) begin
         recv_holdoff <= recv_holdoff - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      frame_out_type exp_f, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.chan0 = rsp_tdata[31:0];
         got.chan1 = rsp_tdata[63:32];
         got.gain  = rsp_tdata[94:64];
         if (expected_frames.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            errors++;
         end else begin
            exp_f = expected_frames.pop_front();
            if (got.chan0 !== exp_f.chan0) begin
               $error("chan0_out expected %h actual %h", exp_f.chan0, got.chan0);
               errors++;
            end
            if (got.chan1 !== exp_f.chan1) begin
               $error("chan1_out expected %h actual %h", exp_f.chan1, got.chan1);
               errors++;
            end
            if (got.gain !== exp_f.gain) begin
               $error("gain_out expected %h actual %h", exp_f.gain, got.gain);
               errors++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [30:0] val);
      csr_wen   <= 1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 0;
      case (idx)
         CSR_THRESHOLD: thr_reg  = val;
         CSR_ATTACK:    atk_reg  = val;
         CSR_RELEASE:   rel_reg  = val;
         CSR_HOLD:      hold_reg = val[15:0];
         CSR_LOOKAHEAD: look_reg = val[7:0];
         CSR_CHANNELS:  nch_reg  = val[1:0];
         default: ;
      endcase
   endtask

   // offer one frame; the model runs when the transaction is accepted
   task automatic send_frame(logic [31:0] s0, logic [31:0] s1, bit zero_out);
      frame_out_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {s1, s0};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = limit_frame(s0, s1);
      if (zero_out) begin
         r.chan0 = 0;
         r.chan1 = 0;
      end
      expected_frames.push_back(r);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (expected_frames.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         3: return {1'b0, thr_reg[30:16], 16'h0} + $urandom_range(0, 32'h2_FFFF);
         4: return -({1'b0, thr_reg} + $urandom_range(0, 32'h2_FFFF));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] pick_coeff();
      case ($urandom_range(0, 3))
         0: return 31'd0;
         1: return Q31_ONE;
         2: return 31'($urandom_range(0, 31'h00FF_FFFF));
         default: return 31'($urandom);
      endcase
   endfunction

   stim_row_type stim_rows [0:11] = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1},
      '{32'h7FFF_FFFF, 32'h0000_0000, 1'b1},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1},
      '{32'h8000_0001, 32'h8000_0000, 1'b1},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1},
      '{32'h4000_FFFF, 32'hC000_0000, 1'b1},  // masked peak equals threshold
      '{32'h4001_0000, 32'h0000_0000, 1'b1},  // just above threshold
      '{32'h0000_0000, 32'hBFFF_0000, 1'b1},
      '{32'h1234_5678, 32'hEDCB_A988, 1'b1},
      '{32'h7FFF_0000, 32'h8001_0000, 1'b1},
      '{32'h0001_0000, 32'hFFFF_0000, 1'b1},
      '{32'h0000_0000, 32'h0000_0000, 1'b1}
   };

   initial begin
      logic [30:0] v;
      thr_reg  = THRESHOLD_RST;
      atk_reg  = ATTACK_RST;
      rel_reg  = RELEASE_RST;
      hold_reg = HOLD_RST;
      look_reg = LOOKAHEAD_RST;
      nch_reg  = NCH_RST;
      foreach (dly_mem[c, i]) dly_mem[c][i] = '0;
      dly_ptr  = 0;
      hold_cnt = HOLD_RST;
      gain_q   = 32'(Q31_ONE);
      env_q    = 32'(Q31_ONE);

      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: reset settings, delay line still holds zeros
      foreach (stim_rows[i]) send_frame(stim_rows[i].s0, stim_rows[i].s1, stim_rows[i].zero_out);
      drain();
      // directed again with the shortest delay, fast attack and no hold
      write_reg(CSR_LOOKAHEAD, 31'd1);
      write_reg(CSR_HOLD, 31'd0);
      write_reg(CSR_ATTACK, Q31_ONE);
      write_reg(CSR_RELEASE, 31'h1000_0000);
      foreach (stim_rows[i]) send_frame(stim_rows[i].s0, stim_rows[i].s1, 1'b0);
      drain();

      // random phases: settings change between phases, pointer carries over
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 3) begin
            send_idle_pct = 19; recv_idle_pct = 49;
         end else if (p < 6) begin
            send_idle_pct = 49; recv_idle_pct = 19;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         if (p == 0) begin
            write_reg(CSR_THRESHOLD, Q31_ONE);
            write_reg(CSR_ATTACK, Q31_ONE);
            write_reg(CSR_RELEASE, Q31_ONE);
            write_reg(CSR_HOLD, 31'h7FFF_FFFF);          // high bits dropped
            write_reg(CSR_LOOKAHEAD, 31'h7FFF_FFFF);     // 255, acts as full depth
            write_reg(CSR_CHANNELS, 31'd3);
         end else if (p == 1) begin
            write_reg(CSR_THRESHOLD, 31'd0);
            write_reg(CSR_ATTACK, 31'd0);
            write_reg(CSR_RELEASE, 31'd0);
            write_reg(CSR_HOLD, 31'd0);
            write_reg(CSR_LOOKAHEAD, 31'd0);
            write_reg(CSR_CHANNELS, 31'd0);
         end else begin
            case ($urandom_range(0, 3))
               0: v = 31'($urandom);
               1: v = 31'h4000_0000;
               2: v = 31'($urandom_range(0, 31'h0010_0000));
               default: v = 31'($urandom_range(31'h1000_0000, 31'h7FFF_FFFF));
            endcase
            write_reg(CSR_THRESHOLD, v);
            write_reg(CSR_ATTACK, pick_coeff());
            write_reg(CSR_RELEASE, pick_coeff());
            write_reg(CSR_HOLD,
                      31'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40)));
            case ($urandom_range(0, 4))
               0: v = 31'd128;
               1: v = 31'd129;
               2: v = 31'd2;
               default: v = 31'($urandom_range(1, 127) | ($urandom & 32'h7FFF_FF00));
            endcase
            write_reg(CSR_LOOKAHEAD, v);
            write_reg(CSR_CHANNELS,
                      (p == 2) ? 31'd1 : 31'(($urandom & 32'h7FFF_FFFC) | 32'd2));
         end
         write_reg(CSR_UNUSED | 3'($urandom_range(0, 1)), 31'($urandom));

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off so the block backs up into its input
            if (p == 2 && n == 50) recv_holdoff = 400;
            send_frame(pick_sample(), pick_sample(), 1'b0);
         end
         drain();
      end

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire
